/* hdl/fus_pkg.sv */
`timescale 1ns / 1ps

package fus_pkg;

   // image and packet geometry
   localparam int ImageBytesWidth = 19;
   localparam int MaxImageBytes   = 262144;
   localparam int BlockBytes      = 1024;
   localparam int PacketBytes     = 128;
   localparam int WordBytes       = 4;
   localparam int PacketsPerBlock = BlockBytes / PacketBytes;
   localparam int BlockShift      = $clog2(BlockBytes);
   localparam int WordShift       = $clog2(WordBytes);

   localparam int CountWidth      = 17;
   localparam int IndexWidth      = 16;
   localparam int CodeWidth       = 5;
   localparam int CmdWidth        = 4;

   // config port
   localparam int CsrIndexWidth   = 2;
   localparam int CsrDataWidth    = ImageBytesWidth;

   localparam logic [CsrIndexWidth-1:0] CSR_IMAGE_BYTES  = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_SINGLE_WORD  = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_NEWEST_SW    = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_MASTER_SIDE  = 2'd3;

   // result queue
   localparam int QueueDepth      = 4;
   localparam int QueuePtrWidth   = $clog2(QueueDepth);
   localparam int QueueCntWidth   = QueuePtrWidth + 1;

   // request kinds
   localparam logic FUNC_START  = 1'b0;
   localparam logic FUNC_STATUS = 1'b1;

   // target status codes
   localparam logic [CodeWidth-1:0] ST_NOT_INIT     = 5'd0;
   localparam logic [CodeWidth-1:0] ST_NO_SPACE     = 5'd1;
   localparam logic [CodeWidth-1:0] ST_READY        = 5'd2;
   localparam logic [CodeWidth-1:0] ST_ERASE_OK     = 5'd3;
   localparam logic [CodeWidth-1:0] ST_ERASE_ERR    = 5'd4;
   localparam logic [CodeWidth-1:0] ST_PROG_OK      = 5'd5;
   localparam logic [CodeWidth-1:0] ST_PROG_ERR     = 5'd6;
   localparam logic [CodeWidth-1:0] ST_CHECKSUM_NOK = 5'd7;
   localparam logic [CodeWidth-1:0] ST_MISSING_PKT  = 5'd8;
   localparam logic [CodeWidth-1:0] ST_FINISH_OK    = 5'd9;
   localparam logic [CodeWidth-1:0] ST_CRC_ERR      = 5'd10;
   localparam logic [CodeWidth-1:0] ST_FREE_OK      = 5'd11;
   localparam logic [CodeWidth-1:0] ST_PART_1       = 5'd12;
   localparam logic [CodeWidth-1:0] ST_PART_2       = 5'd13;
   localparam logic [CodeWidth-1:0] ST_UNRECOGNIZED = 5'd14;
   localparam logic [CodeWidth-1:0] ST_CHECK_OK     = 5'd15;
   localparam logic [CodeWidth-1:0] ST_MARK_OK      = 5'd16;
   localparam logic [CodeWidth-1:0] ST_FORCE_OK     = 5'd17;

   typedef enum logic [CmdWidth-1:0] {
      CMD_START   = 4'd0,
      CMD_ERASE   = 4'd1,
      CMD_SEND    = 4'd2,
      CMD_FINISH  = 4'd3,
      CMD_FREE    = 4'd4,
      CMD_RESET   = 4'd5,
      CMD_CHECK   = 4'd6,
      CMD_GETPART = 4'd7,
      CMD_MARK    = 4'd8,
      CMD_FORCE   = 4'd9
   } cmd_type;

   typedef struct packed {
      logic                   func;
      logic [CodeWidth-1:0]   status_code;
      logic                   prep_ok;
      logic                   reset_ok;
   } req_type;

   typedef struct packed {
      logic                   has_command;
      cmd_type                command;
      logic [IndexWidth-1:0]  packet_index;
      logic                   partition;
      logic                   master_flag;
      logic                   done_res;
      logic                   last;
   } rsp_type;

   typedef struct packed {
      logic [CountWidth-1:0]  total_packets;
      logic                   newest_sw;
      logic                   master_side;
   } cfg_type;

endpackage

/* hdl/fus_cfg.sv */
`timescale 1ns / 1ps

module fus_cfg (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [fus_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [fus_pkg::CsrDataWidth-1:0]    csr_data,
   output fus_pkg::cfg_type                    cfg
);

   logic [fus_pkg::ImageBytesWidth-1:0] image_bytes_ff;
   logic                                single_word_ff;
   logic                                newest_sw_ff;
   logic                                master_side_ff;

   logic [fus_pkg::ImageBytesWidth-1:0] bytes_sat;
   logic [fus_pkg::ImageBytesWidth:0]   word_sum;
   logic [fus_pkg::ImageBytesWidth:0]   block_sum;
   logic [fus_pkg::CountWidth-1:0]      total_words;
   logic [fus_pkg::CountWidth-1:0]      total_blocks;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_bytes_ff  <= '0;
         single_word_ff  <= 1'b0;
         newest_sw_ff    <= 1'b0;
         master_side_ff  <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            fus_pkg::CSR_IMAGE_BYTES:  image_bytes_ff  <= csr_data;
            fus_pkg::CSR_SINGLE_WORD:  single_word_ff  <= csr_data[0];
            fus_pkg::CSR_NEWEST_SW:    newest_sw_ff    <= csr_data[0];
            fus_pkg::CSR_MASTER_SIDE:  master_side_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // packet total: ceil(bytes/4) words, or ceil(bytes/1KiB) blocks of 128-byte packets
   always_comb begin
      bytes_sat = (image_bytes_ff > fus_pkg::ImageBytesWidth'(fus_pkg::MaxImageBytes))
                  ? fus_pkg::ImageBytesWidth'(fus_pkg::MaxImageBytes) : image_bytes_ff;
      word_sum  = {1'b0, bytes_sat} + (fus_pkg::ImageBytesWidth+1)'(fus_pkg::WordBytes - 1);
      block_sum = {1'b0, bytes_sat} + (fus_pkg::ImageBytesWidth+1)'(fus_pkg::BlockBytes - 1);
      total_words  = fus_pkg::CountWidth'(word_sum >> fus_pkg::WordShift);
      total_blocks = fus_pkg::CountWidth'(block_sum >> fus_pkg::BlockShift)
                     * fus_pkg::CountWidth'(fus_pkg::PacketsPerBlock);
   end

   assign cfg.total_packets = single_word_ff ? total_words : total_blocks;
   assign cfg.newest_sw     = newest_sw_ff;
   assign cfg.master_side   = master_side_ff;

endmodule

/* hdl/fus_core.sv */
`timescale 1ns / 1ps

module fus_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              proc,       // request in the input register is retired this cycle
   input  fus_pkg::req_type  req,
   input  fus_pkg::cfg_type  cfg,
   output logic [1:0]        res_n,
   output fus_pkg::rsp_type  res0,
   output fus_pkg::rsp_type  res1
);

   logic [fus_pkg::CountWidth-1:0] pkt_cnt_ff, pkt_cnt_in;
   fus_pkg::cmd_type               last_cmd_ff, last_cmd_in;
   logic                           awaiting_ff, awaiting_in;
   logic                           part_ff, part_in;
   logic                           finished_ff, finished_in;

   logic [fus_pkg::CountWidth-1:0] pkt_dec;
   logic                           done;

   function automatic fus_pkg::rsp_type mk_cmd(input fus_pkg::cmd_type cmd,
                                               input logic [fus_pkg::IndexWidth-1:0] idx,
                                               input logic part, input logic master);
      fus_pkg::rsp_type r;
      r              = '0;
      r.has_command  = 1'b1;
      r.command      = cmd;
      r.packet_index = idx;
      r.partition    = part;
      r.master_flag  = master;
      return r;
   endfunction

   assign pkt_dec = pkt_cnt_ff - fus_pkg::CountWidth'(1);

   always_comb begin
      pkt_cnt_in  = pkt_cnt_ff;
      last_cmd_in = last_cmd_ff;
      awaiting_in = awaiting_ff;
      part_in     = part_ff;
      finished_in = finished_ff;
      res_n       = 2'd0;
      res0        = '0;
      res1        = '0;
      done        = 1'b0;

      if (req.func == fus_pkg::FUNC_START) begin
         finished_in = 1'b0;
         awaiting_in = 1'b0;
         pkt_cnt_in  = '0;
         res_n       = 2'd1;
         res0 = mk_cmd(cfg.newest_sw ? fus_pkg::CMD_FORCE : fus_pkg::CMD_GETPART,
                       '0, part_ff, cfg.master_side);
      end else if (!finished_ff && req.status_code <= fus_pkg::ST_FORCE_OK) begin
         unique case (req.status_code)
            fus_pkg::ST_NOT_INIT, fus_pkg::ST_NO_SPACE: begin
               res_n = 2'd1;
               res0  = mk_cmd(fus_pkg::CMD_FREE, '0, part_ff, cfg.master_side);
               done  = 1'b1;
            end
            fus_pkg::ST_READY: begin
               res_n = 2'd1;
               res0  = mk_cmd(fus_pkg::CMD_ERASE, '0, part_ff, cfg.master_side);
            end
            fus_pkg::ST_ERASE_OK: begin
               res_n      = 2'd1;
               res0       = mk_cmd(fus_pkg::CMD_SEND, pkt_cnt_ff[fus_pkg::IndexWidth-1:0],
                                   part_ff, cfg.master_side);
               pkt_cnt_in = pkt_cnt_ff + fus_pkg::CountWidth'(1);
            end
            fus_pkg::ST_ERASE_ERR, fus_pkg::ST_PROG_ERR, fus_pkg::ST_CRC_ERR: begin
               res_n = 2'd1;
               res0  = mk_cmd(fus_pkg::CMD_FREE, '0, part_ff, cfg.master_side);
            end
            fus_pkg::ST_PROG_OK: begin
               res_n = 2'd1;
               if (pkt_cnt_ff == cfg.total_packets) begin
                  res0 = mk_cmd(fus_pkg::CMD_FINISH, '0, part_ff, cfg.master_side);
               end else begin
                  res0 = mk_cmd(fus_pkg::CMD_SEND, pkt_cnt_ff[fus_pkg::IndexWidth-1:0],
                                part_ff, cfg.master_side);
                  pkt_cnt_in = pkt_cnt_ff + fus_pkg::CountWidth'(1);
               end
            end
            fus_pkg::ST_CHECKSUM_NOK: begin
               res_n = 2'd1;
               priority if (last_cmd_ff == fus_pkg::CMD_SEND) begin
                  // step back and resend; the counter ends where it was
                  res0 = mk_cmd(fus_pkg::CMD_SEND, pkt_dec[fus_pkg::IndexWidth-1:0],
                                part_ff, cfg.master_side);
               end else if (last_cmd_ff == fus_pkg::CMD_START) begin
                  res0 = mk_cmd(fus_pkg::CMD_START, '0, part_ff, cfg.master_side);
               end else begin
                  res0 = mk_cmd(fus_pkg::CMD_FREE, '0, part_ff, cfg.master_side);
               end
            end
            fus_pkg::ST_MISSING_PKT: begin
               res_n = 2'd1;
               res0  = mk_cmd(fus_pkg::CMD_SEND, pkt_dec[fus_pkg::IndexWidth-1:0],
                              part_ff, cfg.master_side);
            end
            fus_pkg::ST_FINISH_OK: begin
               awaiting_in = 1'b1;
               res_n       = 2'd1;
               res0        = mk_cmd(fus_pkg::CMD_FREE, '0, part_ff, cfg.master_side);
            end
            fus_pkg::ST_FREE_OK: begin
               res_n = 2'd1;
               if (awaiting_ff) begin
                  awaiting_in = 1'b0;
                  res0 = mk_cmd(fus_pkg::CMD_RESET, '0, part_ff, cfg.master_side);
                  if (cfg.master_side || req.reset_ok) begin
                     res_n = 2'd2;
                     res1  = mk_cmd(fus_pkg::CMD_CHECK, '0, part_ff, cfg.master_side);
                  end else begin
                     done = 1'b1;
                  end
               end else begin
                  done = 1'b1;
               end
            end
            fus_pkg::ST_PART_1, fus_pkg::ST_PART_2: begin
               part_in = (req.status_code == fus_pkg::ST_PART_2);
               res_n   = 2'd1;
               res0    = mk_cmd(req.prep_ok ? fus_pkg::CMD_START : fus_pkg::CMD_FREE, '0,
                                part_in, cfg.master_side);
            end
            fus_pkg::ST_UNRECOGNIZED: begin
               res_n = 2'd1;
               done  = 1'b1;
            end
            fus_pkg::ST_CHECK_OK: begin
               res_n = 2'd1;
               res0  = mk_cmd(fus_pkg::CMD_MARK, '0, part_ff, cfg.master_side);
            end
            fus_pkg::ST_MARK_OK, fus_pkg::ST_FORCE_OK: begin
               res_n = 2'd1;
               res0  = mk_cmd(fus_pkg::CMD_RESET, '0, part_ff, cfg.master_side);
               done  = 1'b1;
            end
            default: ;
         endcase
      end

      // tag the final result of this request
      if (res_n == 2'd2) begin
         res1.last     = 1'b1;
         res1.done_res = done;
         last_cmd_in   = res1.command;
      end else if (res_n == 2'd1) begin
         res0.last     = 1'b1;
         res0.done_res = done;
         if (res0.has_command) begin
            last_cmd_in = res0.command;
         end
      end
      if (done) begin
         finished_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_cnt_ff  <= '0;
         last_cmd_ff <= fus_pkg::CMD_START;
         awaiting_ff <= 1'b0;
         part_ff     <= 1'b0;
         finished_ff <= 1'b0;
      end else if (proc) begin
         pkt_cnt_ff  <= pkt_cnt_in;
         last_cmd_ff <= last_cmd_in;
         awaiting_ff <= awaiting_in;
         part_ff     <= part_in;
         finished_ff <= finished_in;
      end
   end

endmodule

/* hdl/fus_outq.sv */
`timescale 1ns / 1ps

module fus_outq (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        push_n,
   input  fus_pkg::rsp_type  din0,
   input  fus_pkg::rsp_type  din1,
   output logic              space,      // room for a pair of results
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fus_pkg::rsp_type  dout
);

   fus_pkg::rsp_type                    queue_ff [fus_pkg::QueueDepth];
   logic [fus_pkg::QueuePtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [fus_pkg::QueuePtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [fus_pkg::QueueCntWidth-1:0]   count_ff, count_in;
   logic [fus_pkg::QueuePtrWidth-1:0]   wr_ptr_nxt;
   logic                                pop;

   assign pop        = (count_ff != '0) && !rsp_stall;
   assign space      = count_ff <= fus_pkg::QueueCntWidth'(fus_pkg::QueueDepth - 2);
   assign rsp_valid  = count_ff != '0;
   assign dout       = queue_ff[rd_ptr_ff];
   assign wr_ptr_nxt = wr_ptr_ff + fus_pkg::QueuePtrWidth'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + fus_pkg::QueuePtrWidth'(push_n);
      rd_ptr_in = rd_ptr_ff + fus_pkg::QueuePtrWidth'(pop);
      count_in  = count_ff + fus_pkg::QueueCntWidth'(push_n)
                  - fus_pkg::QueueCntWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= din0;
      end
      if (push_n == 2'd2) begin
         queue_ff[wr_ptr_nxt] <= din1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= fus_pkg::QueueCntWidth'(fus_pkg::QueueDepth))
      else $error("result queue overfilled");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && dout.done_res) |-> dout.last)
      else $error("done mark on a result that is not last");

   a_bare_is_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !dout.has_command) |-> (dout.done_res && dout.last))
      else $error("result without command is not a done mark");

endmodule

/* hdl/firmware_update_sequencer_unit.sv */
`timescale 1ns / 1ps

// Channel   | Ports                                 | Direction | Handshake
// ----------+---------------------------------------+-----------+-------------------
// request   | req_func/status_code/prep_ok/reset_ok | in        | req_valid/req_stall
// response  | rsp_has_command ... rsp_last          | out       | rsp_valid/rsp_stall
// config    | csr_index, csr_data                   | in        | csr_write
//
// A request is registered, decoded combinationally, and its one or two responses are
// pushed into a 4-entry response queue; the first response is valid once the push is
// registered. Sustained rate is one request per cycle while the queue has room for a
// pair; the response port drains one per cycle unless stalled, so the reset+check
// pair after a free-ok leaves the port one response at a time.
// Reset (synchronous, active high) clears the sequencer state, config and queue.
// Response stall backs up the queue; the request side stalls only when the queue
// cannot take a pair.

module firmware_update_sequencer_unit (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                csr_write,
   input  logic [fus_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [fus_pkg::CsrDataWidth-1:0]    csr_data,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_func,
   input  logic [fus_pkg::CodeWidth-1:0]       req_status_code,
   input  logic                                req_prep_ok,
   input  logic                                req_reset_ok,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_has_command,
   output logic [fus_pkg::CmdWidth-1:0]        rsp_command,
   output logic [fus_pkg::IndexWidth-1:0]      rsp_packet_index,
   output logic                                rsp_partition,
   output logic                                rsp_master_flag,
   output logic                                rsp_done_res,
   output logic                                rsp_last
);

   fus_pkg::cfg_type cfg;
   fus_pkg::req_type req_ff;
   logic             req_valid_ff;
   logic             q_space;
   logic             proc;
   logic             req_take;
   logic [1:0]       res_n;
   logic [1:0]       push_n;
   fus_pkg::rsp_type res0;
   fus_pkg::rsp_type res1;
   fus_pkg::rsp_type dout;

   // the held request retires once the queue can take a pair of responses
   assign proc      = req_valid_ff && q_space;
   assign req_stall = req_valid_ff && !q_space;
   assign req_take  = req_valid && !req_stall;
   assign push_n    = proc ? res_n : 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_take) begin
         req_valid_ff <= 1'b1;
      end else if (proc) begin
         req_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff.func        <= req_func;
         req_ff.status_code <= req_status_code;
         req_ff.prep_ok     <= req_prep_ok;
         req_ff.reset_ok    <= req_reset_ok;
      end
   end

   fus_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   fus_core u_core (
      .clock (clock),
      .reset (reset),
      .proc  (proc),
      .req   (req_ff),
      .cfg   (cfg),
      .res_n (res_n),
      .res0  (res0),
      .res1  (res1)
   );

   fus_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push_n    (push_n),
      .din0      (res0),
      .din1      (res1),
      .space     (q_space),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dout      (dout)
   );

   assign rsp_has_command  = dout.has_command;
   assign rsp_command      = dout.command;
   assign rsp_packet_index = dout.packet_index;
   assign rsp_partition    = dout.partition;
   assign rsp_master_flag  = dout.master_flag;
   assign rsp_done_res     = dout.done_res;
   assign rsp_last         = dout.last;

endmodule
